// File: src/avr_pkg.sv
`timescale 1ns / 1ps

package avr_pkg;

  // Field widths
  localparam int unsigned ANGLE_BITS = 12;
  localparam int unsigned COORD_BITS = 16;

  // Quarter-wave sine table geometry
  localparam int unsigned SINE_BITS = 15;
  localparam int unsigned QTR       = 1 << (ANGLE_BITS - 2);
  localparam int unsigned TAB_DEPTH = QTR + 1;
  localparam int unsigned TAB_AW    = ANGLE_BITS - 1;

  // Datapath widths: signed sine/cosine, product, product sum with rounding headroom
  localparam int unsigned TRIG_W = SINE_BITS + 2;
  localparam int unsigned PROD_W = COORD_BITS + TRIG_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // Pi/2 in Q2.62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // Rotation axis codes; the fourth code leaves the vector as it is
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] vz;
    logic [ANGLE_BITS-1:0]        turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
    logic signed [COORD_BITS-1:0] rz;
  } out_item_t;

  // (a * b) >> 62, kept to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // round(32767 * sin(pi/2 * k / QTR)) by an integer Taylor series
  function automatic logic [SINE_BITS-1:0] sine_q15(input int unsigned k);
    logic [63:0]        frac;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] acc;
    int unsigned        n;
    frac = 64'(k) << (64 - ANGLE_BITS);
    x    = mul_q62(HALF_PI_Q62, frac);
    x2   = mul_q62(x, x);
    term = x;
    acc  = $signed(x);
    for (n = 1; n < 64 && term != 64'd0; n++) begin
      term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    r = mul_q62(64'(acc), 64'd32767 << 47);
    r = (r + (64'd1 << 46)) >> 47;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_BITS-1:0];
  endfunction

  // Add half an LSB, floor-shift out the Q1.15 fraction, clamp to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] round_sat(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    t  = (v + SUM_W'(1 << (SINE_BITS - 1))) >>> SINE_BITS;
    if (t > hi) begin
      t = hi;
    end else if (t < lo) begin
      t = lo;
    end
    return t[COORD_BITS-1:0];
  endfunction

endpackage

// File: src/axis_vector_rotation_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                      Handshake
// input     start, busy, in_data       taken at an edge with start high and busy low
// result    out_valid, out_data        one-cycle strobe, no backpressure
//
// One transaction per cycle; each result passes through the registered sine ROM read,
// the product register and the result register, one stage each.
// busy is high only during reset and the cycle it is released.
// rst_n is synchronous; it clears the stage valid bits, never the payload.
// The receiver cannot stall, so nothing upstream ever waits on it.

module axis_vector_rotation_unit
  import avr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  // Constant quarter-wave sine table
  logic [SINE_BITS-1:0] sine_rom [TAB_DEPTH];

  for (genvar k = 0; k < TAB_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_q15(k);
  end

  logic busy_r;
  logic accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Hold busy through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Stage 1: register the vector and read both table taps
  logic                         s1_valid_r;
  logic [1:0]                   s1_op_r;
  logic [1:0]                   s1_quad_r;
  logic signed [COORD_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [SINE_BITS-1:0]         s1_tap_a_r, s1_tap_b_r;
  logic [TAB_AW-1:0]            addr_a, addr_b;

  assign addr_a = {1'b0, in_data.turn_angle[ANGLE_BITS-3:0]};
  assign addr_b = TAB_AW'(QTR) - addr_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r    <= in_data.op;
    s1_quad_r  <= in_data.turn_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    s1_x_r     <= in_data.vx;
    s1_y_r     <= in_data.vy;
    s1_z_r     <= in_data.vz;
    s1_tap_a_r <= sine_rom[addr_a];
    s1_tap_b_r <= sine_rom[addr_b];
  end

  // Stage 2: fold the quadrant into sine and cosine, pick the pair, multiply
  logic signed [TRIG_W-1:0]     tap_a, tap_b, sin_v, cos_v;
  logic signed [COORD_BITS-1:0] pa, pb;
  logic signed [PROD_W-1:0]     p_ac_nxt, p_bs_nxt, p_as_nxt, p_bc_nxt;

  assign tap_a = $signed({2'b00, s1_tap_a_r});
  assign tap_b = $signed({2'b00, s1_tap_b_r});

  always_comb begin
    case (s1_quad_r)
      2'd0: begin
        sin_v = tap_a;
        cos_v = tap_b;
      end
      2'd1: begin
        sin_v = tap_b;
        cos_v = -tap_a;
      end
      2'd2: begin
        sin_v = -tap_a;
        cos_v = -tap_b;
      end
      default: begin
        sin_v = -tap_b;
        cos_v = tap_a;
      end
    endcase
  end

  assign pa = (s1_op_r == AXIS_X) ? s1_y_r : s1_x_r;
  assign pb = (s1_op_r == AXIS_Z) ? s1_y_r : s1_z_r;

  assign p_ac_nxt = pa * cos_v;
  assign p_bs_nxt = pb * sin_v;
  assign p_as_nxt = pa * sin_v;
  assign p_bc_nxt = pb * cos_v;

  logic                         s2_valid_r;
  logic [1:0]                   s2_op_r;
  logic signed [COORD_BITS-1:0] s2_x_r, s2_y_r, s2_z_r;
  logic signed [PROD_W-1:0]     p_ac_r, p_bs_r, p_as_r, p_bc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r <= s1_op_r;
    s2_x_r  <= s1_x_r;
    s2_y_r  <= s1_y_r;
    s2_z_r  <= s1_z_r;
    p_ac_r  <= p_ac_nxt;
    p_bs_r  <= p_bs_nxt;
    p_as_r  <= p_as_nxt;
    p_bc_r  <= p_bc_nxt;
  end

  // Stage 3: sum, round, saturate and route back onto the axes
  logic signed [SUM_W-1:0]      sum_a, sum_b;
  logic signed [COORD_BITS-1:0] na, nb;
  out_item_t                    out_data_nxt;
  out_item_t                    out_data_r;
  logic                         out_valid_r;

  assign sum_a = SUM_W'(p_ac_r) - SUM_W'(p_bs_r);
  assign sum_b = SUM_W'(p_as_r) + SUM_W'(p_bc_r);
  assign na    = round_sat(sum_a);
  assign nb    = round_sat(sum_b);

  always_comb begin
    case (s2_op_r)
      AXIS_X: begin
        out_data_nxt.rx = s2_x_r;
        out_data_nxt.ry = na;
        out_data_nxt.rz = nb;
      end
      AXIS_Y: begin
        out_data_nxt.rx = na;
        out_data_nxt.ry = s2_y_r;
        out_data_nxt.rz = nb;
      end
      AXIS_Z: begin
        out_data_nxt.rx = na;
        out_data_nxt.ry = nb;
        out_data_nxt.rz = s2_z_r;
      end
      default: begin
        out_data_nxt.rx = s2_x_r;
        out_data_nxt.ry = s2_y_r;
        out_data_nxt.rz = s2_z_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every accepted transaction yields a strobe once it has passed the pipeline
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted transaction produced no result");

  // No strobe without a matching accepted transaction earlier in the pipeline
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result strobe without a matching transaction");

  // The unused axis code passes the vector through untouched
  a_no_axis_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.op == AXIS_NONE |-> ##3
      (out_data.rx == $past(in_data.vx, 3) && out_data.ry == $past(in_data.vy, 3)
       && out_data.rz == $past(in_data.vz, 3)))
    else $error("unused axis code altered the vector");

  // A rotation about Z never modifies the z coordinate
  a_axis_kept: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.op == AXIS_Z |-> ##3 out_data.rz == $past(in_data.vz, 3))
    else $error("Z rotation changed the z coordinate");

endmodule
